### sv/qco_pkg.sv
// Shared types for the quadrilateral corner ordering pipeline.
package qco_pkg;

  // Angle class of a corner offset, in ascending angle order
  typedef enum logic [1:0] {
    CLS_LOWER = 2'd0,  // dy < 0, angle in (-pi, 0)
    CLS_ZERO  = 2'd1,  // dy == 0 and dx >= 0, angle 0 (centroid too)
    CLS_UPPER = 2'd2,  // dy > 0, angle in (0, pi)
    CLS_PI    = 2'd3   // dy == 0 and dx < 0, angle pi
  } angle_cls_e;

  // Sign of the cross product a x b for one corner pair
  typedef struct packed {
    logic pos;  // a x b > 0
    logic neg;  // a x b < 0
  } cross_sign_t;

endpackage

### sv/qco_cross_cmp.sv
// Two-stage cross product sign unit for one pair of corner offsets.
module qco_cross_cmp #(
  parameter int DW = 19
) (
  input  logic                 clk_i,
  input  logic                 prod_en_i,
  input  logic                 cmp_en_i,
  input  logic signed [DW-1:0] a_dx_i,
  input  logic signed [DW-1:0] a_dy_i,
  input  logic signed [DW-1:0] b_dx_i,
  input  logic signed [DW-1:0] b_dy_i,
  output qco_pkg::cross_sign_t sign_o
);
  import qco_pkg::*;

  localparam int PW = 2 * DW;

  logic signed [PW-1:0] p_ab_q, p_ba_q;
  cross_sign_t          sign_q;

  // Product stage: the two terms of a x b
  always_ff @(posedge clk_i) begin
    if (prod_en_i) begin
      p_ab_q <= PW'(a_dx_i) * PW'(b_dy_i);
      p_ba_q <= PW'(a_dy_i) * PW'(b_dx_i);
    end
  end

  // Compare stage: sign of the difference
  always_ff @(posedge clk_i) begin
    if (cmp_en_i) begin
      sign_q.pos <= p_ab_q > p_ba_q;
      sign_q.neg <= p_ab_q < p_ba_q;
    end
  end

  assign sign_o = sign_q;

endmodule

### sv/quad_corner_order_top.sv
// Top level of the quadrilateral corner ordering pipeline.
//
// Takes the four corners of one quadrilateral and returns them as top-left,
// top-right, bottom-right, bottom-left. Corners are sorted by angle around
// the centroid (ascending from just above -pi to pi, like atan2), exactly,
// using four times the centroid offset, half-plane classes and cross product
// signs; corners of equal angle keep their input order. The sorted ring then
// starts at the corner with the smallest x+y (first in sorted order on a
// tie). Output coordinates are input bits passed through unchanged.
// The block takes one item per cycle while in_stall_o is low. Each item passes
// five register stages (input register, centroid offsets, cross product
// multipliers, product and sum compares, rank and reorder) before its result
// is offered.
// A stall on the output side backs up only as far as the pipeline is full.
module quad_corner_order_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] in_x0_i,
  input  logic [COORD_BITS-1:0] in_y0_i,
  input  logic [COORD_BITS-1:0] in_x1_i,
  input  logic [COORD_BITS-1:0] in_y1_i,
  input  logic [COORD_BITS-1:0] in_x2_i,
  input  logic [COORD_BITS-1:0] in_y2_i,
  input  logic [COORD_BITS-1:0] in_x3_i,
  input  logic [COORD_BITS-1:0] in_y3_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] tl_x_o,
  output logic [COORD_BITS-1:0] tl_y_o,
  output logic [COORD_BITS-1:0] tr_x_o,
  output logic [COORD_BITS-1:0] tr_y_o,
  output logic [COORD_BITS-1:0] br_x_o,
  output logic [COORD_BITS-1:0] br_y_o,
  output logic [COORD_BITS-1:0] bl_x_o,
  output logic [COORD_BITS-1:0] bl_y_o
);
  import qco_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int SW   = CB + 2;  // coordinate sum
  localparam int DW   = CB + 3;  // 4*x - sum
  localparam int SUMW = CB + 1;  // x + y
  localparam int NS   = 5;       // pipeline stages

  // Pipeline control: a stage loads when empty or when the next one moves
  logic [NS-1:0] v_q, en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  // Stage 1: input register and coordinate sums
  logic [CB-1:0] in_x[4], in_y[4];
  logic [SW-1:0] sx_d, sy_d;
  logic [CB-1:0] s1_x_q[4], s1_y_q[4];
  logic [SW-1:0] s1_sx_q, s1_sy_q;

  always_comb begin
    in_x[0] = in_x0_i;  in_y[0] = in_y0_i;
    in_x[1] = in_x1_i;  in_y[1] = in_y1_i;
    in_x[2] = in_x2_i;  in_y[2] = in_y2_i;
    in_x[3] = in_x3_i;  in_y[3] = in_y3_i;
    sx_d = '0;
    sy_d = '0;
    for (int i = 0; i < 4; i++) begin
      sx_d = sx_d + {{2{in_x[i][CB-1]}}, in_x[i]};
      sy_d = sy_d + {{2{in_y[i][CB-1]}}, in_y[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 4; i++) begin
        s1_x_q[i] <= in_x[i];
        s1_y_q[i] <= in_y[i];
      end
      s1_sx_q <= sx_d;
      s1_sy_q <= sy_d;
    end
  end

  // Stage 2: scaled centroid offsets, angle class, x+y
  logic signed [DW-1:0]   dx_d[4], dy_d[4];
  angle_cls_e             cls_d[4];
  logic signed [SUMW-1:0] psum_d[4];

  logic [CB-1:0]          s2_x_q[4], s2_y_q[4];
  logic signed [DW-1:0]   s2_dx_q[4], s2_dy_q[4];
  angle_cls_e             s2_cls_q[4];
  logic signed [SUMW-1:0] s2_psum_q[4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dx_d[i] = $signed({s1_x_q[i][CB-1], s1_x_q[i], 2'b00})
              - $signed({s1_sx_q[SW-1], s1_sx_q});
      dy_d[i] = $signed({s1_y_q[i][CB-1], s1_y_q[i], 2'b00})
              - $signed({s1_sy_q[SW-1], s1_sy_q});
      if (dy_d[i] < 0) begin
        cls_d[i] = CLS_LOWER;
      end else if (dy_d[i] == 0) begin
        cls_d[i] = (dx_d[i] < 0) ? CLS_PI : CLS_ZERO;
      end else begin
        cls_d[i] = CLS_UPPER;
      end
      psum_d[i] = $signed({s1_x_q[i][CB-1], s1_x_q[i]})
                + $signed({s1_y_q[i][CB-1], s1_y_q[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 4; i++) begin
        s2_x_q[i]    <= s1_x_q[i];
        s2_y_q[i]    <= s1_y_q[i];
        s2_dx_q[i]   <= dx_d[i];
        s2_dy_q[i]   <= dy_d[i];
        s2_cls_q[i]  <= cls_d[i];
        s2_psum_q[i] <= psum_d[i];
      end
    end
  end

  // Stage 3: carried fields (products live in the pair units)
  logic [CB-1:0]          s3_x_q[4], s3_y_q[4];
  angle_cls_e             s3_cls_q[4];
  logic signed [SUMW-1:0] s3_psum_q[4];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int i = 0; i < 4; i++) begin
        s3_x_q[i]    <= s2_x_q[i];
        s3_y_q[i]    <= s2_y_q[i];
        s3_cls_q[i]  <= s2_cls_q[i];
        s3_psum_q[i] <= s2_psum_q[i];
      end
    end
  end

  // Stage 4: x+y compares and carried fields
  logic [CB-1:0] s4_x_q[4], s4_y_q[4];
  angle_cls_e    s4_cls_q[4];
  logic          s4_slt_q[4][4], s4_seq_q[4][4];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int i = 0; i < 4; i++) begin
        s4_x_q[i]   <= s3_x_q[i];
        s4_y_q[i]   <= s3_y_q[i];
        s4_cls_q[i] <= s3_cls_q[i];
        for (int j = 0; j < 4; j++) begin
          s4_slt_q[i][j] <= s3_psum_q[i] < s3_psum_q[j];
          s4_seq_q[i][j] <= s3_psum_q[i] == s3_psum_q[j];
        end
      end
    end
  end

  // Pair units: cross sign for every pair, aligned with stage 4
  logic less[4][4];  // less[a][b]: a's angle strictly below b's

  for (genvar ga = 0; ga < 4; ga++) begin : g_row
    assign less[ga][ga] = 1'b0;
    for (genvar gb = ga + 1; gb < 4; gb++) begin : g_pair
      cross_sign_t sgn;
      logic        same_cls, open_cls;

      qco_cross_cmp #(
        .DW(DW)
      ) u_cross (
        .clk_i     (clk_i),
        .prod_en_i (en[2]),
        .cmp_en_i  (en[3]),
        .a_dx_i    (s2_dx_q[ga]),
        .a_dy_i    (s2_dy_q[ga]),
        .b_dx_i    (s2_dx_q[gb]),
        .b_dy_i    (s2_dy_q[gb]),
        .sign_o    (sgn)
      );

      assign same_cls = s4_cls_q[ga] == s4_cls_q[gb];
      assign open_cls = s4_cls_q[ga] == CLS_LOWER || s4_cls_q[ga] == CLS_UPPER;

      // Different half-planes order by class; open half-planes by cross sign
      assign less[ga][gb] = same_cls ? (open_cls && sgn.pos)
                                     : (s4_cls_q[ga] < s4_cls_q[gb]);
      assign less[gb][ga] = same_cls ? (open_cls && sgn.neg)
                                     : (s4_cls_q[gb] < s4_cls_q[ga]);
    end
  end

  // Stage 5: stable rank, start corner, rotate into output register
  logic [1:0]    rank[4], slot[4], start_rank;
  logic          is_start[4];
  logic [CB-1:0] ox_d[4], oy_d[4];
  logic [CB-1:0] out_x_q[4], out_y_q[4];

  always_comb begin
    // Rank: corners strictly before, plus earlier corners of equal angle
    for (int i = 0; i < 4; i++) begin
      rank[i] = 2'd0;
      for (int j = 0; j < 4; j++) begin
        if (j != i && (less[j][i] || (j < i && !less[i][j]))) begin
          rank[i] = rank[i] + 2'd1;
        end
      end
    end
    // Start: smallest x+y, lowest rank on a tie
    start_rank = 2'd0;
    for (int i = 0; i < 4; i++) begin
      is_start[i] = 1'b1;
      for (int j = 0; j < 4; j++) begin
        if (j != i && !(s4_slt_q[i][j] || (s4_seq_q[i][j] && rank[i] < rank[j]))) begin
          is_start[i] = 1'b0;
        end
      end
      if (is_start[i]) start_rank = start_rank | rank[i];
    end
    // Output slot of each corner, then route
    for (int i = 0; i < 4; i++) begin
      slot[i] = rank[i] - start_rank;
    end
    for (int k = 0; k < 4; k++) begin
      ox_d[k] = '0;
      oy_d[k] = '0;
      for (int i = 0; i < 4; i++) begin
        if (slot[i] == 2'(k)) begin
          ox_d[k] = s4_x_q[i];
          oy_d[k] = s4_y_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int k = 0; k < 4; k++) begin
        out_x_q[k] <= ox_d[k];
        out_y_q[k] <= oy_d[k];
      end
    end
  end

  assign tl_x_o = out_x_q[0];
  assign tl_y_o = out_y_q[0];
  assign tr_x_o = out_x_q[1];
  assign tr_y_o = out_y_q[1];
  assign br_x_o = out_x_q[2];
  assign br_y_o = out_y_q[2];
  assign bl_x_o = out_x_q[3];
  assign bl_y_o = out_y_q[3];

endmodule
